>>> rtl/core/byte_quota_admission_with_wait_queues_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the byte quota admission core
// Short forms for same-cycle and next-cycle implications with sync reset.
// ---------------------------------------------------------------------------
`ifndef BYTE_QUOTA_ADMISSION_WITH_WAIT_QUEUES_CORE_ASSERT_SVH
`define BYTE_QUOTA_ADMISSION_WITH_WAIT_QUEUES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BQA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bqa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BQA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bqa: next-cycle check failed");

`endif

>>> rtl/core/bqa_pkg.sv
// ---------------------------------------------------------------------------
// bqa_pkg
// Types, codes and helpers shared by the byte quota admission core.
// ---------------------------------------------------------------------------
package bqa_pkg;

    typedef enum logic [1:0] {
        CMD_REQ    = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_UNREG  = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    localparam logic [2:0] CFG_ENABLED   = 3'd0;
    localparam logic [2:0] CFG_TOTAL     = 3'd1;
    localparam logic [2:0] CFG_QUOTA     = 3'd2;
    localparam logic [2:0] CFG_MIN_FREE  = 3'd3;
    localparam logic [2:0] CFG_BUF_BYTES = 3'd4;

    localparam logic [31:0] RESET_TOTAL     = 32'd67108864;
    localparam logic [31:0] RESET_QUOTA     = 32'd67108864;
    localparam logic [20:0] RESET_BUF_BYTES = 21'd4096;

    localparam int OUTQ_DEPTH = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_RM_INIT,
        ST_RM_WALK,
        ST_FINISH,
        ST_TICK,
        ST_NOTE,
        ST_REPLY
    } t_state;

    // Decoded item as it waits between the front and the back.
    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  client;
        logic        neg;
        logic [32:0] mag;
        logic        io;
        logic        dov;
        logic [19:0] free;
        logic [40:0] prod;
    } t_work;

    typedef struct packed {
        logic        kind;
        logic [3:0]  client;
        logic        granted;
        logic [31:0] gbytes;
        logic [31:0] remaining;
        logic [4:0]  waiting;
        logic [4:0]  over;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        enabled;
        logic [31:0] total;
        logic [31:0] quota;
        logic [19:0] min_free;
    } t_cfg;

    function automatic logic [31:0] sat32(input logic [33:0] v);
        return (v[33:32] != 2'b00) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

endpackage

>>> rtl/core/bqa_front.sv
// ---------------------------------------------------------------------------
// bqa_front
// Accepts items, decodes the byte delta and forms the buffer product.
// ---------------------------------------------------------------------------
module bqa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          i_command,
    input  logic [3:0]          i_client,
    input  logic signed [32:0]  i_byte_delta,
    input  logic                i_for_disk_io,
    input  logic                i_disk_overloaded,
    input  logic [19:0]         i_free_buffers,
    input  logic [20:0]         i_buffer_bytes,
    output logic                o_valid,
    input  logic                i_pop,
    output bqa_pkg::t_work      o_work
);
    import bqa_pkg::*;

    t_work       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [32:0] w_raw;
    logic [20:0] w_bb;
    t_work       w_new;
    logic        w_wr, w_rd;

    assign w_raw = i_byte_delta;
    // A zero buffer size is taken as one.
    assign w_bb  = (i_buffer_bytes == 21'd0) ? 21'd1 : i_buffer_bytes;

    always_comb begin
        w_new.cmd    = t_cmd'(i_command);
        w_new.client = i_client;
        w_new.neg    = w_raw[32];
        w_new.mag    = w_raw[32] ? (33'd0 - w_raw) : w_raw;
        w_new.io     = i_for_disk_io;
        w_new.dov    = i_disk_overloaded;
        w_new.free   = i_free_buffers;
        w_new.prod   = {21'd0, i_free_buffers} * {20'd0, w_bb};
    end

    assign full    = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= w_new;
    end

endmodule

>>> rtl/core/bqa_outq.sv
// ---------------------------------------------------------------------------
// bqa_outq
// Small result queue between the back end and the result ports.
// ---------------------------------------------------------------------------
module bqa_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  bqa_pkg::t_result  i_data,
    output logic              o_full,
    output logic              o_empty,
    input  logic              i_rd,
    output bqa_pkg::t_result  o_data
);
    import bqa_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);

    t_result       r_mem [OUTQ_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (PW+1)'(OUTQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_wr) - (PW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

>>> rtl/core/bqa_back.sv
// ---------------------------------------------------------------------------
// bqa_back
// Sequencer that applies one item to the client table and wait queues.
// ---------------------------------------------------------------------------
module bqa_back #(
    parameter int CLIENTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bqa_pkg::t_cfg     i_cfg,
    input  logic              i_work_valid,
    input  bqa_pkg::t_work    i_work,
    output logic              o_work_pop,
    output logic              o_res_valid,
    input  logic              i_res_full,
    output bqa_pkg::t_result  o_res
);
    import bqa_pkg::*;

    localparam int IDX_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CNT_W = $clog2(CLIENTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CLIENTS);

    t_state r_state, n_state;
    t_work  r_work;

    logic [31:0]      r_held   [CLIENTS];
    logic [31:0]      r_wanted [CLIENTS];
    logic [IDX_W-1:0] r_link   [CLIENTS];
    logic [CLIENTS-1:0] r_wait, r_over;
    logic [IDX_W-1:0] r_head [2];
    logic [IDX_W-1:0] r_tail [2];
    logic [CNT_W-1:0] r_cnt  [2];
    logic [31:0]      r_remaining;

    logic [32:0]      r_rem;
    logic [33:0]      r_sum;
    logic             r_grant, r_q, r_newover, r_dopush;
    logic [IDX_W-1:0] r_p, r_lx, r_note_c;
    logic [CNT_W-1:0] r_i;
    logic [31:0]      r_note_w;

    logic [IDX_W-1:0] w_c, w_ra, w_la, w_link;
    logic             w_in_range, w_wt, w_ov;
    logic [31:0]      w_held, w_want, w_quota, w_newheld, w_held_grant, w_rem_grant;
    logic [32:0]      w_relsum;
    logic             w_minlow, w_low_rem, w_low_tick;
    logic             w_newover_rel, w_over_req, w_grant, w_tick_go;
    logic [31:0]      w_want_add, w_unreg_rem, w_rel_rem, w_sub_held;
    logic [CNT_W-1:0] w_rq_cnt;
    logic [IDX_W-1:0] w_rq_head, w_rq_tail;
    logic             w_rm_hit_head, w_walk_end, w_walk_hit;

    assign w_c        = IDX_W'(r_work.client);
    assign w_in_range = (32'(r_work.client) < CLIENTS);
    assign w_ra       = (r_state == ST_TICK) ? r_head[0] : w_c;
    assign w_la       = (r_state == ST_RM_WALK) ? r_p : w_ra;
    assign w_held     = r_held[w_ra];
    assign w_want     = r_wanted[w_ra];
    assign w_wt       = r_wait[w_ra];
    assign w_ov       = r_over[w_ra];
    assign w_link     = r_link[w_la];

    assign w_quota    = (i_cfg.quota < i_cfg.total) ? i_cfg.quota : i_cfg.total;
    assign w_minlow   = (r_work.free < i_cfg.min_free);
    // free * bytes <= rem is the same as free <= rem / bytes.
    assign w_low_rem  = w_minlow || (r_work.prod <= 41'(r_rem));
    assign w_low_tick = w_minlow || (r_work.prod <= 41'(r_remaining));

    assign w_newheld     = r_sum[31:0];
    assign w_relsum      = {1'b0, w_newheld} + {1'b0, w_want};
    assign w_newover_rel = ({1'b0, w_quota} < w_relsum);
    assign w_rel_rem     = sat32({1'b0, r_rem} - 34'(w_newheld));
    assign w_over_req    = ({2'b00, w_quota} < r_sum);
    assign w_grant       = !w_wt && ((r_sum == 34'd0) ||
                           ((!r_work.io || !r_work.dov) && !w_low_rem &&
                            (r_sum < {1'b0, r_rem}) && !w_over_req));
    assign w_held_grant  = sat32(r_sum);
    assign w_sub_held    = w_held_grant;
    assign w_rem_grant   = sat32({1'b0, r_rem} - 34'(w_sub_held));
    assign w_tick_go     = (r_cnt[0] != '0) && !r_work.dov && !w_low_tick &&
                           (w_want <= r_remaining);
    assign w_want_add    = sat32(34'(w_want) + 34'(r_work.mag));
    assign w_unreg_rem   = sat32(34'(r_remaining) + 34'(w_held));

    assign w_rq_cnt      = r_cnt[r_q];
    assign w_rq_head     = r_head[r_q];
    assign w_rq_tail     = r_tail[r_q];
    assign w_rm_hit_head = (w_rq_head == w_c);
    assign w_walk_end    = (r_i >= w_rq_cnt);
    assign w_walk_hit    = (w_link == w_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_work_pop  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.remaining = r_remaining;
        o_res.waiting   = 5'(r_cnt[0]);
        o_res.over      = 5'(r_cnt[1]);
        case (r_state)
            ST_IDLE: begin
                if (i_work_valid) begin
                    o_work_pop = 1'b1;
                    n_state    = ST_CALC;
                end
            end
            ST_CALC: begin
                if (r_work.cmd == CMD_TICK)        n_state = ST_TICK;
                else if (!w_in_range)              n_state = ST_REPLY;
                else if (r_work.cmd != CMD_REQ)    n_state = w_wt ? ST_RM_INIT : ST_FINISH;
                else if (!i_cfg.enabled)           n_state = ST_REPLY;
                else                               n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (r_work.neg) begin
                    n_state = (w_wt && w_ov && !w_newover_rel) ? ST_RM_INIT : ST_REPLY;
                end else if (w_grant) begin
                    n_state = ST_REPLY;
                end else if (w_wt && (w_ov != w_over_req)) begin
                    n_state = ST_RM_INIT;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_RM_INIT: begin
                if (w_rq_cnt == '0 || w_rm_hit_head) n_state = ST_FINISH;
                else                                 n_state = ST_RM_WALK;
            end
            ST_RM_WALK: begin
                if (w_walk_end || w_walk_hit) n_state = ST_FINISH;
            end
            ST_FINISH: n_state = ST_REPLY;
            ST_TICK:   n_state = w_tick_go ? ST_NOTE : ST_REPLY;
            ST_NOTE: begin
                o_res.kind    = 1'b1;
                o_res.client  = 4'(r_note_c);
                o_res.granted = 1'b1;
                o_res.gbytes  = r_note_w;
                if (!i_res_full) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_TICK;
                end
            end
            ST_REPLY: begin
                o_res.client  = r_work.client;
                o_res.granted = r_grant;
                o_res.last    = 1'b1;
                if (!i_res_full) begin
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Client table, queue pointers and budget.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLIENTS; k++) begin
                r_held[k]   <= '0;
                r_wanted[k] <= '0;
            end
            r_wait      <= '0;
            r_over      <= '0;
            r_head[0]   <= '0;
            r_head[1]   <= '0;
            r_tail[0]   <= '0;
            r_tail[1]   <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_remaining <= RESET_TOTAL;
        end else begin
            case (r_state)
                ST_DECIDE: begin
                    if (r_work.neg) begin
                        r_held[w_c] <= w_newheld;
                        r_remaining <= w_rel_rem;
                    end else if (w_grant) begin
                        r_held[w_c] <= w_held_grant;
                        r_remaining <= w_rem_grant;
                    end
                end
                ST_RM_INIT: begin
                    if (w_rq_cnt != '0 && w_rm_hit_head) begin
                        r_head[r_q] <= w_link;
                        r_cnt[r_q]  <= w_rq_cnt - 1'b1;
                    end
                end
                ST_RM_WALK: begin
                    if (!w_walk_end && w_walk_hit) begin
                        if (w_rq_tail == w_c) r_tail[r_q] <= r_p;
                        r_cnt[r_q] <= w_rq_cnt - 1'b1;
                    end
                end
                ST_FINISH: begin
                    if (r_work.cmd == CMD_REQ) begin
                        if (r_dopush) begin
                            r_over[w_c] <= r_newover;
                            if (r_cnt[r_newover] == '0) r_head[r_newover] <= w_c;
                            r_tail[r_newover] <= w_c;
                            if (r_cnt[r_newover] < CNT_MAX)
                                r_cnt[r_newover] <= r_cnt[r_newover] + 1'b1;
                        end
                        r_wait[w_c] <= 1'b1;
                        if (!r_work.neg) r_wanted[w_c] <= w_want_add;
                    end else begin
                        r_wanted[w_c] <= '0;
                        r_over[w_c]   <= 1'b0;
                        r_wait[w_c]   <= 1'b0;
                        if (r_work.cmd == CMD_UNREG) begin
                            r_remaining <= w_unreg_rem;
                            r_held[w_c] <= '0;
                        end
                    end
                end
                ST_TICK: begin
                    if (w_tick_go) begin
                        r_head[0]        <= w_link;
                        r_cnt[0]         <= r_cnt[0] - 1'b1;
                        r_remaining      <= r_remaining - w_want;
                        r_held[w_ra]     <= sat32(34'(w_held) + 34'(w_want));
                        r_wanted[w_ra]   <= '0;
                        r_wait[w_ra]     <= 1'b0;
                        r_over[w_ra]     <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers and queue links.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_work_valid) r_work <= i_work;
            end
            ST_CALC: begin
                r_grant <= (r_work.cmd == CMD_REQ) && w_in_range;
                r_q     <= w_ov;
                r_rem   <= {1'b0, r_remaining} + {1'b0, w_held};
                if (r_work.neg)
                    r_sum <= ({1'b0, w_held} > r_work.mag) ?
                             {2'b00, w_held - r_work.mag[31:0]} : 34'd0;
                else
                    r_sum <= 34'(w_want) + 34'(w_held) + 34'(r_work.mag);
            end
            ST_DECIDE: begin
                if (r_work.neg) begin
                    r_grant   <= 1'b1;
                    r_q       <= 1'b1;
                    r_newover <= 1'b0;
                    r_dopush  <= 1'b1;
                end else begin
                    r_grant   <= w_grant;
                    r_q       <= w_ov;
                    r_newover <= w_over_req;
                    r_dopush  <= !w_wt || (w_ov != w_over_req);
                end
            end
            ST_RM_INIT: begin
                r_lx <= w_link;
                r_p  <= w_rq_head;
                r_i  <= CNT_W'(1);
            end
            ST_RM_WALK: begin
                if (!w_walk_end && w_walk_hit) r_link[r_p] <= r_lx;
                r_p <= w_link;
                r_i <= r_i + 1'b1;
            end
            ST_FINISH: begin
                if (r_work.cmd == CMD_REQ && r_dopush && r_cnt[r_newover] != '0)
                    r_link[r_tail[r_newover]] <= w_c;
            end
            ST_TICK: begin
                r_grant  <= 1'b0;
                r_note_c <= r_head[0];
                r_note_w <= w_want;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/byte_quota_admission_with_wait_queues_core.sv
// ---------------------------------------------------------------------------
// byte_quota_admission_with_wait_queues_core
// Byte budget admission controller with normal and over-quota wait queues.
// ---------------------------------------------------------------------------
// Sequencing: the back-end sequencer takes one item at a time and accepts
//   the next only after the last reply is offered; removing a queued client
//   walks its queue, one link per cycle. A tick grants normal-queue heads
//   in order, sending a grant notice for each.
// Reset: synchronous, active low; clears all client entries and queues at
//   once, loads the registers with their defaults and the budget with the
//   default total. Queue links are not cleared.
module byte_quota_admission_with_wait_queues_core #(
    parameter int CLIENTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Item side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_command,
    input  logic [3:0]         i_client,
    input  logic signed [32:0] i_byte_delta,
    input  logic               i_for_disk_io,
    input  logic               i_disk_overloaded,
    input  logic [19:0]        i_free_buffers,
    // Result side
    output logic               empty,
    input  logic               pop,
    output logic               o_kind,
    output logic [3:0]         o_client_out,
    output logic               o_granted,
    output logic [31:0]        o_granted_bytes,
    output logic [31:0]        o_remaining_out,
    output logic [4:0]         o_waiting_clients,
    output logic [4:0]         o_over_quota_clients,
    output logic               o_last,
    // Register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bqa_pkg::*;

    `include "byte_quota_admission_with_wait_queues_core_assert.svh"

    // Configuration registers. Writes are always taken; an unknown index
    // is dropped. Writing the total does not touch the remaining budget.
    logic        r_enabled;
    logic [31:0] r_total, r_quota;
    logic [19:0] r_min_free;
    logic [20:0] r_buf_bytes;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_total     <= RESET_TOTAL;
            r_quota     <= RESET_QUOTA;
            r_min_free  <= '0;
            r_buf_bytes <= RESET_BUF_BYTES;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLED:   r_enabled   <= i_cfg_data[0];
                CFG_TOTAL:     r_total     <= i_cfg_data;
                CFG_QUOTA:     r_quota     <= i_cfg_data;
                CFG_MIN_FREE:  r_min_free  <= i_cfg_data[19:0];
                CFG_BUF_BYTES: r_buf_bytes <= i_cfg_data[20:0];
                default: ;
            endcase
        end
    end

    t_cfg w_cfg;
    assign w_cfg.enabled  = r_enabled;
    assign w_cfg.total    = r_total;
    assign w_cfg.quota    = r_quota;
    assign w_cfg.min_free = r_min_free;

    // The front decodes each item and precomputes free buffers times
    // buffer size, so the back can test for low buffers with a compare.
    t_work   w_work;
    logic    w_work_valid, w_work_pop;
    t_result w_res, w_out;
    logic    w_res_valid, w_res_full;

    bqa_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_client          (i_client),
        .i_byte_delta      (i_byte_delta),
        .i_for_disk_io     (i_for_disk_io),
        .i_disk_overloaded (i_disk_overloaded),
        .i_free_buffers    (i_free_buffers),
        .i_buffer_bytes    (r_buf_bytes),
        .o_valid           (w_work_valid),
        .i_pop             (w_work_pop),
        .o_work            (w_work)
    );

    // The back owns the client table and both linked wait queues. It
    // handles one item at a time and stalls when the result queue fills.
    bqa_back #(
        .CLIENTS (CLIENTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_work_pop   (w_work_pop),
        .o_res_valid  (w_res_valid),
        .i_res_full   (w_res_full),
        .o_res        (w_res)
    );

    // Results wait here so the consumer can stall without holding up
    // the sequencer until the queue is full.
    bqa_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_rd    (pop),
        .o_data  (w_out)
    );

    assign o_kind               = w_out.kind;
    assign o_client_out         = w_out.client;
    assign o_granted            = w_out.granted;
    assign o_granted_bytes      = w_out.gbytes;
    assign o_remaining_out      = w_out.remaining;
    assign o_waiting_clients    = w_out.waiting;
    assign o_over_quota_clients = w_out.over;
    assign o_last               = w_out.last;

    // A grant notice always grants and is never the final result of a tick.
    `BQA_ASSERT_IMP(a_notice_form, i_clk, i_rst_n, !empty && o_kind, o_granted && !o_last)
    // The sequencer never offers a result the queue cannot take.
    `BQA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, w_res_valid, !w_res_full)
    // The back never takes an item in the cycle after taking one.
    `BQA_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, w_work_pop, !w_work_pop)

endmodule

>>> test/byte_quota_admission_with_wait_queues_core_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the byte quota admission core
// Drives requests, releases, cancels, unregisters and service ticks through
// the queue-style ports under random idling and one long result stall. Each
// accepted item runs through a behavioral model of the byte budget and both
// wait queues, and every result is compared with the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_quota_admission_with_wait_queues_core_tb;
    import bqa_pkg::*;

    localparam int NCLIENT      = 16;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 40;
    localparam int SETTLE       = 40;     // covers a reply plus a full queue walk
    localparam int STALL_CYCLES = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam logic [63:0] MAX32   = 64'hFFFF_FFFF;
    localparam logic [63:0] SUM_MAX = 64'hFF_FFFF_FFFF;

    typedef struct {
        t_cmd               cmd;
        logic [3:0]         client;
        logic signed [32:0] delta;
        logic               io;
        logic               dov;
        logic [19:0]        free;
        bit                 typed;     // reply granted/remaining typed in below
        bit                 g;
        logic [31:0]        rem;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_command;
    logic [3:0]         i_client;
    logic signed [32:0] i_byte_delta;
    logic               i_for_disk_io;
    logic               i_disk_overloaded;
    logic [19:0]        i_free_buffers;
    logic               empty;
    logic               pop;
    logic               o_kind;
    logic [3:0]         o_client_out;
    logic               o_granted;
    logic [31:0]        o_granted_bytes;
    logic [31:0]        o_remaining_out;
    logic [4:0]         o_waiting_clients;
    logic [4:0]         o_over_quota_clients;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    byte_quota_admission_with_wait_queues_core #(.CLIENTS(NCLIENT)) u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_command           (i_command),
        .i_client            (i_client),
        .i_byte_delta        (i_byte_delta),
        .i_for_disk_io       (i_for_disk_io),
        .i_disk_overloaded   (i_disk_overloaded),
        .i_free_buffers      (i_free_buffers),
        .empty               (empty),
        .pop                 (pop),
        .o_kind              (o_kind),
        .o_client_out        (o_client_out),
        .o_granted           (o_granted),
        .o_granted_bytes     (o_granted_bytes),
        .o_remaining_out     (o_remaining_out),
        .o_waiting_clients   (o_waiting_clients),
        .o_over_quota_clients(o_over_quota_clients),
        .o_last              (o_last),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // -----------------------------------------------------------------------
    // Behavioral copy of the admission state. Index 0 of the queue arrays is
    // the normal wait queue and index 1 the over-quota queue.
    // -----------------------------------------------------------------------
    logic        m_enabled;
    logic [31:0] m_total;
    logic [31:0] m_quota;
    logic [19:0] m_min_free;
    logic [20:0] m_buf_bytes;

    logic [31:0] held[NCLIENT];
    logic [31:0] wanted[NCLIENT];
    bit          waiting[NCLIENT];
    bit          over_mark[NCLIENT];
    int          link[NCLIENT];
    int          q_head[2];
    int          q_tail[2];
    int          q_len[2];
    logic [63:0] q_sum[2];
    logic [31:0] budget_left;
    int          holders;

    t_result     expected_results[$];
    int          errors;

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > MAX32) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void model_reset();
        m_enabled   = 1'b1;
        m_total     = RESET_TOTAL;
        m_quota     = RESET_QUOTA;
        m_min_free  = '0;
        m_buf_bytes = RESET_BUF_BYTES;
        for (int i = 0; i < NCLIENT; i++) begin
            held[i] = '0; wanted[i] = '0; waiting[i] = 0; over_mark[i] = 0; link[i] = 0;
        end
        for (int q = 0; q < 2; q++) begin
            q_head[q] = 0; q_tail[q] = 0; q_len[q] = 0; q_sum[q] = '0;
        end
        budget_left = RESET_TOTAL;
        holders     = 0;
    endfunction

    function automatic void model_config(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_ENABLED:   m_enabled   = data[0];
            CFG_TOTAL:     m_total     = data;
            CFG_QUOTA:     m_quota     = data;
            CFG_MIN_FREE:  m_min_free  = data[19:0];
            CFG_BUF_BYTES: m_buf_bytes = data[20:0];
            default: ;
        endcase
    endfunction

    function automatic void sum_add(input int q, input logic [63:0] v);
        q_sum[q] = (q_sum[q] + v > SUM_MAX) ? SUM_MAX : q_sum[q] + v;
    endfunction

    function automatic void sum_sub(input int q, input logic [63:0] v);
        q_sum[q] = (q_sum[q] > v) ? q_sum[q] - v : '0;
    endfunction

    function automatic void enqueue(input int q, input int c);
        if (q_len[q] == 0) q_head[q] = c;
        else link[q_tail[q]] = c;
        q_tail[q] = c;
        if (q_len[q] < NCLIENT) q_len[q]++;
    endfunction

    // Unlinks a client anywhere in a queue by walking it from the head.
    function automatic void unlink(input int q, input int c);
        int p;
        int nx;
        if (q_len[q] == 0) return;
        if (q_head[q] == c) begin
            q_head[q] = link[c];
            q_len[q]--;
            return;
        end
        p = q_head[q];
        for (int i = 1; i < q_len[q]; i++) begin
            nx = link[p];
            if (nx == c) begin
                link[p] = link[c];
                if (q_tail[q] == c) q_tail[q] = p;
                q_len[q]--;
                return;
            end
            p = nx;
        end
    endfunction

    function automatic void move_queue(input int c, input bit to_over);
        if (over_mark[c] == to_over) return;
        unlink(over_mark[c], c);
        sum_sub(over_mark[c], wanted[c]);
        over_mark[c] = to_over;
        enqueue(to_over, c);
        sum_add(to_over, wanted[c]);
    endfunction

    function automatic void leave_wait(input int c);
        if (!waiting[c]) return;
        unlink(over_mark[c], c);
        sum_sub(over_mark[c], wanted[c]);
        wanted[c]    = '0;
        over_mark[c] = 0;
        waiting[c]   = 0;
    endfunction

    // Supply is low when free buffers are under the minimum or under the budget in buffers plus one.
    function automatic bit buffers_low(input logic [63:0] rem, input logic [19:0] free);
        logic [63:0] bb;
        logic [63:0] thr;
        bb  = (m_buf_bytes == 0) ? 64'd1 : 64'(m_buf_bytes);
        thr = rem / bb + 1;
        if (thr < 64'(m_min_free)) thr = 64'(m_min_free);
        return 64'(free) < thr;
    endfunction

    function automatic void count_holder(input bit had, input int c);
        bit has;
        has = held[c] > 0;
        if (had && !has && holders > 0) holders--;
        if (!had && has && holders < 31) holders++;
    endfunction

    function automatic void add_result(input logic kind, input logic [3:0] c, input logic g,
                                       input logic [31:0] gb, input logic last);
        t_result r;
        r.kind      = kind;
        r.client    = c;
        r.granted   = g;
        r.gbytes    = gb;
        r.remaining = budget_left;
        r.waiting   = 5'(q_len[0]);
        r.over      = 5'(q_len[1]);
        r.last      = last;
        expected_results.push_back(r);
    endfunction

    // Applies one accepted item to the model and queues the results it causes.
    function automatic void admit_item(input t_row it);
        int          c;
        int          h;
        bit          neg;
        logic [63:0] mag;
        logic [63:0] quota_eff;
        logic [63:0] rem;
        logic [63:0] req;
        logic [31:0] w;
        bit          had;
        bit          grant;
        bit          over;
        c         = int'(it.client);
        neg       = it.delta[32];
        mag       = neg ? 64'h2_0000_0000 - 64'({1'b0, it.delta}) : 64'({1'b0, it.delta});
        quota_eff = (m_quota < m_total) ? 64'(m_quota) : 64'(m_total);
        case (it.cmd)
            CMD_TICK: begin
                // Grant normal-queue heads in order while they fit.
                while (!it.dov && !buffers_low(64'(budget_left), it.free) && q_len[0] > 0) begin
                    h = q_head[0];
                    if (wanted[h] > budget_left) break;
                    w = wanted[h];
                    unlink(0, h);
                    sum_sub(0, w);
                    budget_left = budget_left - w;
                    had = held[h] > 0;
                    held[h] = clamp32(64'(held[h]) + 64'(w));
                    count_holder(had, h);
                    wanted[h] = '0;
                    waiting[h] = 0;
                    over_mark[h] = 0;
                    add_result(1'b1, 4'(h), 1'b1, w, 1'b0);
                end
                add_result(1'b0, it.client, 1'b0, '0, 1'b1);
            end
            CMD_CANCEL, CMD_UNREG: begin
                leave_wait(c);
                if (it.cmd == CMD_UNREG) begin
                    budget_left = clamp32(64'(budget_left) + 64'(held[c]));
                    if (held[c] > 0 && holders > 0) holders--;
                    held[c] = '0;
                end
                add_result(1'b0, it.client, 1'b0, '0, 1'b1);
            end
            default: begin
                if (!m_enabled) begin
                    add_result(1'b0, it.client, 1'b1, '0, 1'b1);
                end else begin
                    rem   = 64'(budget_left) + 64'(held[c]);
                    had   = held[c] > 0;
                    grant = 1;
                    if (neg) begin
                        held[c] = (64'(held[c]) > mag) ? 32'(64'(held[c]) - mag) : '0;
                        rem = rem - 64'(held[c]);
                        budget_left = clamp32(rem);
                        count_holder(had, c);
                        if (waiting[c] && over_mark[c])
                            move_queue(c, quota_eff < 64'(held[c]) + 64'(wanted[c]));
                    end else begin
                        req   = 64'(wanted[c]) + 64'(held[c]) + mag;
                        over  = quota_eff < req;
                        grant = !waiting[c] && (req == 0 || ((!it.io || !it.dov) &&
                                !buffers_low(rem, it.free) && req < rem && !over));
                        if (grant) begin
                            held[c] = clamp32(req);
                            rem = rem - 64'(held[c]);
                        end else begin
                            if (waiting[c]) begin
                                move_queue(c, over);
                            end else begin
                                over_mark[c] = over;
                                enqueue(over, c);
                                waiting[c] = 1;
                            end
                            sum_add(over_mark[c], mag);
                            rem = rem - 64'(held[c]);
                            wanted[c] = clamp32(64'(wanted[c]) + mag);
                        end
                        budget_left = clamp32(rem);
                        count_holder(had, c);
                    end
                    add_result(1'b0, it.client, grant, '0, 1'b1);
                end
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Clock and watchdog
    // -----------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    int idle_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Result side: random stalls, one long hold-off, and field checks.
    // -----------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    initial begin
        int      gap;
        int      popped;
        t_result e;
        pop    = 1'b0;
        popped = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            // Well into the run, sit on the result side long enough for the
            // input side to back up and stall.
            if (popped == 60) begin
                pop <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            popped++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, client %0d", $time, o_client_out);
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("kind", 32'(e.kind), 32'(o_kind));
                check_field("client_out", 32'(e.client), 32'(o_client_out));
                check_field("granted", 32'(e.granted), 32'(o_granted));
                check_field("granted_bytes", e.gbytes, o_granted_bytes);
                check_field("remaining_out", e.remaining, o_remaining_out);
                check_field("waiting_clients", 32'(e.waiting), 32'(o_waiting_clients));
                check_field("over_quota_clients", 32'(e.over), 32'(o_over_quota_clients));
                check_field("last", 32'(e.last), 32'(o_last));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Item side
    // -----------------------------------------------------------------------
    task automatic send_item(input t_row it);
        int          gap;
        int          idx;
        t_result     r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command         <= it.cmd;
        i_client          <= it.client;
        i_byte_delta      <= it.delta;
        i_for_disk_io     <= it.io;
        i_disk_overloaded <= it.dov;
        i_free_buffers    <= it.free;
        push              <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        admit_item(it);
        // Rows with a hand-worked answer replace the reply's key fields.
        if (it.typed) begin
            idx = expected_results.size() - 1;
            r = expected_results[idx];
            r.granted   = it.g;
            r.remaining = it.rem;
            expected_results[idx] = r;
        end
    endtask

    // Leaves i_cfg_valid high so back-to-back writes need no lowering.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_config(idx, data);
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_row row(input t_cmd cmd, input int c, input logic signed [32:0] d,
                                 input logic io, input logic dov, input logic [19:0] free);
        t_row r;
        r.cmd = cmd; r.client = 4'(c); r.delta = d; r.io = io; r.dov = dov; r.free = free;
        r.typed = 0; r.g = 0; r.rem = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input t_row r, input bit g, input logic [31:0] rem);
        t_row t;
        t = r; t.typed = 1; t.g = g; t.rem = rem;
        return t;
    endfunction

    // Random item, weighted toward small requests and releases so that
    // grants, waits and queue moves all happen often.
    function automatic t_row random_item();
        t_row        r;
        int          pick;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        r.cmd = (pick < 60) ? CMD_REQ : (pick < 70) ? CMD_CANCEL :
                (pick < 78) ? CMD_UNREG : CMD_TICK;
        r.client = 4'($urandom_range(0, NCLIENT - 1));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            r.delta = 33'($urandom_range(0, 32'h40_0000));
        end else if (pick < 75) begin
            r.delta = 33'sd0 - 33'($urandom_range(1, 32'h40_0000));
        end else if (pick < 85) begin
            r.delta = 33'($urandom_range(0, 32'h800_0000));
        end else if (pick < 95) begin
            v = $urandom;
            r.delta = {1'($urandom_range(0, 1)), v};
            if (r.delta == 33'h1_0000_0000) r.delta = 33'h1_0000_0001;
        end else begin
            r.delta = ($urandom_range(0, 1) != 0) ? 33'h0_FFFF_FFFF : 33'h1_0000_0001;
        end
        r.io   = 1'($urandom_range(0, 1));
        r.dov  = ($urandom_range(0, 4) == 0);
        r.free = ($urandom_range(0, 4) == 0) ? 20'($urandom) :
                 20'hF_FFFF - 20'($urandom_range(0, 1000));
        r.typed = 0; r.g = 0; r.rem = '0;
        return r;
    endfunction

    initial begin
        t_row        dir_rows[$];
        logic [31:0] cfg_total[PHASES];
        logic [31:0] cfg_quota[PHASES];
        logic [31:0] cfg_min_free[PHASES];
        logic [31:0] cfg_buf[PHASES];
        logic        cfg_en[PHASES];
        i_rst_n           = 1'b0;
        push              = 1'b0;
        i_command         = CMD_REQ;
        i_client          = '0;
        i_byte_delta      = '0;
        i_for_disk_io     = 1'b0;
        i_disk_overloaded = 1'b0;
        i_free_buffers    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_ENABLED;
        i_cfg_data        = '0;
        errors            = 0;
        model_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset settings (budget and quota 64 MiB).
        dir_rows.push_back(typed_row(row(CMD_REQ, 0, 33'sd0, 0, 0, 20'hF_FFFF),
                                     1, 32'd67108864));
        dir_rows.push_back(typed_row(row(CMD_REQ, 1, 33'sd1000, 0, 0, 20'hF_FFFF),
                                     1, 32'd67107864));
        // Largest request: far over quota, so the client waits in that queue.
        dir_rows.push_back(typed_row(row(CMD_REQ, 2, 33'h0_FFFF_FFFF, 0, 0, 20'hF_FFFF),
                                     0, 32'd67107864));
        // Disk I/O while the disk is overloaded, then low buffers: both wait.
        dir_rows.push_back(typed_row(row(CMD_REQ, 3, 33'sd100, 1, 1, 20'hF_FFFF),
                                     0, 32'd67107864));
        dir_rows.push_back(typed_row(row(CMD_REQ, 4, 33'sd100, 0, 0, 20'd0),
                                     0, 32'd67107864));
        dir_rows.push_back(row(CMD_REQ, 3, 33'sd50, 0, 0, 20'hF_FFFF));
        // Ticks that are blocked, then one that serves the normal queue.
        dir_rows.push_back(row(CMD_TICK, 9, 33'sd0, 0, 1, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_TICK, 9, 33'sd0, 0, 0, 20'd0));
        dir_rows.push_back(row(CMD_TICK, 15, 33'sd0, 1, 0, 20'hF_FFFF));
        // Largest release while waiting over quota; then cancel it.
        dir_rows.push_back(row(CMD_REQ, 2, 33'h1_0000_0001, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_CANCEL, 2, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_CANCEL, 5, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_UNREG, 1, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_UNREG, 6, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_REQ, 5, 33'sd5000, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_REQ, 5, -33'sd1000, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_REQ, 5, 33'h1_0000_0001, 0, 0, 20'hF_FFFF));
        // A request equal to the whole budget is not below it, so it waits.
        dir_rows.push_back(row(CMD_REQ, 7, 33'sd67108864, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_REQ, 8, 33'sd67108865, 0, 0, 20'hF_FFFF));
        // Zero bytes while waiting keeps the client waiting.
        dir_rows.push_back(row(CMD_REQ, 7, 33'sd0, 0, 0, 20'hF_FFFF));
        // Release by an over-quota waiter that holds nothing; it stays over quota.
        dir_rows.push_back(row(CMD_REQ, 8, -33'sd1000, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_UNREG, 7, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_TICK, 0, 33'sd0, 0, 0, 20'hF_FFFF));
        dir_rows.push_back(row(CMD_UNREG, 8, 33'sd0, 0, 0, 20'hF_FFFF));
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        push <= 1'b0;
        drain();

        // Register settings per random phase, extremes included.
        cfg_en       = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        cfg_total    = '{32'd67108864, 32'd67108864, 32'd67108864, 32'hFFFF_FFFF,
                         32'd0, 32'd33554432};
        cfg_quota    = '{32'd67108864, 32'd8388608, 32'd1000, 32'hFFFF_FFFF,
                         32'd0, 32'd16777216};
        cfg_min_free = '{32'd0, 32'd0, 32'd0, 32'hF_FFFF, 32'd1000, 32'd0};
        cfg_buf      = '{32'd4096, 32'd1, 32'd4096, 32'd1048576, 32'd0, 32'd65536};
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_ENABLED, 32'(cfg_en[p]));
            write_reg(CFG_TOTAL, cfg_total[p]);
            write_reg(CFG_QUOTA, cfg_quota[p]);
            write_reg(CFG_MIN_FREE, cfg_min_free[p]);
            write_reg(CFG_BUF_BYTES, cfg_buf[p]);
            if (p == 1) write_reg(3'd7, 32'hFFFF_FFFF);  // index with no register
            i_cfg_valid <= 1'b0;
            @(posedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
            push <= 1'b0;
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> byte_quota_admission_with_wait_queues_core.f
+incdir+rtl/core
rtl/core/bqa_pkg.sv
rtl/core/bqa_front.sv
rtl/core/bqa_outq.sv
rtl/core/bqa_back.sv
rtl/core/byte_quota_admission_with_wait_queues_core.sv
test/byte_quota_admission_with_wait_queues_core_tb.sv
